// ===== rtl/core/cfpr_pkg.sv =====
package cfpr_pkg;

  // Bytes carried by one result word
  localparam int CHUNK_BYTES = 8;

  // Result status codes
  localparam logic [1:0] STATUS_CHUNK    = 2'd0;
  localparam logic [1:0] STATUS_HEADER   = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  // Frame type, identifier bits 10..8
  localparam logic [2:0] HDR_SINGLE = 3'b001;
  localparam logic [2:0] HDR_START  = 3'b011;
  localparam logic [2:0] HDR_CONT   = 3'b101;
  localparam logic [2:0] HDR_END    = 3'b111;

  // Request from the frame intake to the chunk emitter
  typedef struct packed {
    logic       go;
    logic [1:0] status;
    logic       bcast;
  } cfpr_cmd_t;

endpackage

// ===== rtl/core/cfpr_ram.sv =====
module cfpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/cfpr_emit.sv =====
module cfpr_emit #(
  parameter int PDU_BYTES = 256,
  localparam int AW = $clog2(PDU_BYTES),
  localparam int FW = $clog2(PDU_BYTES + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  cfpr_pkg::cfpr_cmd_t cmd,
  input  logic [FW-1:0]       total,
  output logic                busy,
  output logic                rd_en,
  output logic [AW-1:0]       rd_addr,
  input  logic [7:0]          rd_data,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          status,
  output logic                is_broadcast,
  output logic [3:0]          chunk_valid,
  output logic [7:0]          bytes [cfpr_pkg::CHUNK_BYTES],
  output logic                last_chunk
);

  import cfpr_pkg::*;

  typedef enum logic [2:0] {
    E_IDLE = 3'b001,
    E_READ = 3'b010,
    E_PUSH = 3'b100
  } emit_state_t;

  emit_state_t state;
  logic [FW-1:0] pos;
  logic [FW-1:0] total_r;
  logic [3:0]    n;
  logic [3:0]    k;
  logic          cap_en;
  logic [2:0]    cap_idx;
  logic [1:0]    stat;
  logic          bcast;
  logic [7:0]    stage [CHUNK_BYTES];

  logic [FW-1:0] pos_adv;
  logic [FW-1:0] rem_adv;
  logic [3:0]    n_adv;
  logic [3:0]    n_first;
  logic          last_c;
  logic          load;

  // Next chunk position and size
  always_comb begin
    pos_adv = pos + FW'(n);
    rem_adv = total_r - pos_adv;
    n_adv   = (rem_adv > FW'(CHUNK_BYTES)) ? 4'(CHUNK_BYTES) : rem_adv[3:0];
    n_first = (total > FW'(CHUNK_BYTES)) ? 4'(CHUNK_BYTES) : total[3:0];
    last_c  = (stat != STATUS_CHUNK) || (pos_adv >= total_r);
    load    = (state == E_PUSH) && (!out_valid || !out_stall);
  end

  assign busy    = (state != E_IDLE);
  assign rd_en   = (state == E_READ) && (k < n);
  assign rd_addr = AW'(pos + FW'(k));

  // Walk the buffer one byte a cycle, then hand the chunk to the output word; error results skip the walk
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= E_IDLE;
      cap_en    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        E_IDLE: begin
          if (cmd.go) begin
            stat    <= cmd.status;
            bcast   <= cmd.bcast;
            total_r <= total;
            pos     <= '0;
            k       <= '0;
            cap_en  <= 1'b0;
            for (int i = 0; i < CHUNK_BYTES; i++) begin
              stage[i] <= '0;
            end
            if (cmd.status == STATUS_CHUNK) begin
              n     <= n_first;
              state <= E_READ;
            end else begin
              n     <= '0;
              state <= E_PUSH;
            end
          end
        end
        E_READ: begin
          if (cap_en) begin
            stage[cap_idx] <= rd_data;
          end
          cap_en  <= (k < n);
          cap_idx <= k[2:0];
          if (k == n) begin
            state <= E_PUSH;
          end else begin
            k <= k + 4'd1;
          end
        end
        E_PUSH: begin
          if (load) begin
            status       <= stat;
            is_broadcast <= bcast;
            chunk_valid  <= n;
            bytes        <= stage;
            last_chunk   <= last_c;
            if (last_c) begin
              state <= E_IDLE;
            end else begin
              pos    <= pos_adv;
              n      <= n_adv;
              k      <= '0;
              cap_en <= 1'b0;
              for (int i = 0; i < CHUNK_BYTES; i++) begin
                stage[i] <= '0;
              end
              state <= E_READ;
            end
          end
        end
        default: state <= E_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/can_frame_pdu_reassembler_top.sv =====
// Frame intake: an accepted frame writes its bytes into the PDU buffer one a cycle, and
// further input is stalled until the write is done; dropped frames are not written.
// A completed PDU is read back one byte a cycle through the buffer read port, while
// input is stalled until the last chunk is in the output register.
// Errors give one result word.
// Reset (rst, synchronous) clears control state and sets slave_address to 1; no buffer clear.
module can_frame_pdu_reassembler_top #(
  parameter int PDU_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [10:0] frame_id,
  input  logic [3:0]  frame_length,
  input  logic [7:0]  data_0,
  input  logic [7:0]  data_1,
  input  logic [7:0]  data_2,
  input  logic [7:0]  data_3,
  input  logic [7:0]  data_4,
  input  logic [7:0]  data_5,
  input  logic [7:0]  data_6,
  input  logic [7:0]  data_7,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic        is_broadcast,
  output logic [3:0]  chunk_valid,
  output logic [7:0]  byte_0,
  output logic [7:0]  byte_1,
  output logic [7:0]  byte_2,
  output logic [7:0]  byte_3,
  output logic [7:0]  byte_4,
  output logic [7:0]  byte_5,
  output logic [7:0]  byte_6,
  output logic [7:0]  byte_7,
  output logic        last_chunk
);

  import cfpr_pkg::*;

  localparam int AW = $clog2(PDU_BYTES);
  localparam int FW = $clog2(PDU_BYTES + 1);

  typedef enum logic [1:0] {
    I_IDLE  = 2'b01,
    I_WRITE = 2'b10
  } intake_state_t;

  intake_state_t state;
  logic [7:0]    slave_address;
  logic          halted;
  logic [FW-1:0] fill_index;
  logic [7:0]    frame_bytes [CHUNK_BYTES];
  logic [FW-1:0] wr_base;
  logic [3:0]    wr_len;
  logic [3:0]    wr_cnt;
  logic          wr_complete;
  logic          wr_bcast;

  logic [7:0]    addr;
  logic [2:0]    hdr;
  logic          match;
  logic          bcast_c;
  logic [3:0]    len_c;
  logic          restart;
  logic          complete;
  logic          bad_hdr;
  logic [FW-1:0] base_c;
  logic [FW:0]   sum_c;
  logic          ovf;
  logic          in_take;
  logic          wr_done;
  logic [FW-1:0] fill_sum;

  cfpr_cmd_t     cmd;
  logic          emit_busy;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;
  logic [7:0]    out_bytes [CHUNK_BYTES];

  // Decode the incoming frame
  always_comb begin
    addr     = frame_id[7:0];
    hdr      = frame_id[10:8];
    match    = frame_id[8] && ((addr == slave_address) || (addr == 8'd0));
    bcast_c  = (addr == 8'd0);
    len_c    = (frame_length > 4'd8) ? 4'd8 : frame_length;
    restart  = 1'b0;
    complete = 1'b0;
    bad_hdr  = 1'b0;
    unique case (hdr) inside
      HDR_SINGLE: begin
        restart  = 1'b1;
        complete = 1'b1;
      end
      HDR_START: restart = 1'b1;
      HDR_CONT:  restart = 1'b0;
      HDR_END:   complete = 1'b1;
      default:   bad_hdr = 1'b1;
    endcase
    base_c = restart ? '0 : fill_index;
    sum_c  = {1'b0, base_c} + (FW+1)'(len_c);
    ovf    = sum_c > (FW+1)'(PDU_BYTES);
  end

  assign in_stall = (state != I_IDLE) || emit_busy;
  assign in_take  = in_valid && !in_stall;
  assign wr_done  = (state == I_WRITE) && (wr_cnt == wr_len);
  assign fill_sum = wr_base + FW'(wr_len);

  // Request results: errors at accept, chunks when a PDU's last byte is written
  always_comb begin
    cmd = '0;
    if (in_take && !halted && match) begin
      if (bad_hdr) begin
        cmd.go     = 1'b1;
        cmd.status = STATUS_HEADER;
      end else if (ovf) begin
        cmd.go     = 1'b1;
        cmd.status = STATUS_OVERFLOW;
      end
    end else if (wr_done && wr_complete) begin
      cmd.go     = 1'b1;
      cmd.status = STATUS_CHUNK;
      cmd.bcast  = wr_bcast;
    end
  end

  assign ram_we    = (state == I_WRITE) && (wr_cnt < wr_len);
  assign ram_waddr = AW'(wr_base + FW'(wr_cnt));

  // Intake control: latch the frame, write its bytes, update the fill index
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= I_IDLE;
      slave_address <= 8'd1;
      halted        <= 1'b0;
      fill_index    <= '0;
    end else begin
      if (cfg_we) begin
        slave_address <= cfg_wdata;
      end
      unique case (state)
        I_IDLE: begin
          if (in_take && !halted && match) begin
            if (bad_hdr) begin
              halted <= 1'b1;
            end else if (ovf) begin
              fill_index <= '0;
            end else begin
              frame_bytes[0] <= data_0;
              frame_bytes[1] <= data_1;
              frame_bytes[2] <= data_2;
              frame_bytes[3] <= data_3;
              frame_bytes[4] <= data_4;
              frame_bytes[5] <= data_5;
              frame_bytes[6] <= data_6;
              frame_bytes[7] <= data_7;
              wr_base     <= base_c;
              wr_len      <= len_c;
              wr_cnt      <= '0;
              wr_complete <= complete;
              wr_bcast    <= bcast_c;
              state       <= I_WRITE;
            end
          end
        end
        I_WRITE: begin
          if (wr_done) begin
            fill_index <= fill_sum;
            state      <= I_IDLE;
          end else begin
            wr_cnt <= wr_cnt + 4'd1;
          end
        end
        default: state <= I_IDLE;
      endcase
    end
  end

  cfpr_ram #(
    .WIDTH (8),
    .DEPTH (PDU_BYTES)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (frame_bytes[wr_cnt[2:0]]),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  cfpr_emit #(
    .PDU_BYTES (PDU_BYTES)
  ) u_emit (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .total        (fill_sum),
    .busy         (emit_busy),
    .rd_en        (ram_re),
    .rd_addr      (ram_raddr),
    .rd_data      (ram_rdata),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .is_broadcast (is_broadcast),
    .chunk_valid  (chunk_valid),
    .bytes        (out_bytes),
    .last_chunk   (last_chunk)
  );

  assign byte_0 = out_bytes[0];
  assign byte_1 = out_bytes[1];
  assign byte_2 = out_bytes[2];
  assign byte_3 = out_bytes[3];
  assign byte_4 = out_bytes[4];
  assign byte_5 = out_bytes[5];
  assign byte_6 = out_bytes[6];
  assign byte_7 = out_bytes[7];

endmodule
